### rtl/rva_pkg.sv
`default_nettype none
package rva_pkg;

  localparam int CordicSteps = 30;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

  function automatic logic signed [CordicW-1:0] atan_turn(input int i);
    logic signed [CordicW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sd536870912;   1: r = 34'sd316933406;   2: r = 34'sd167458907;
      3: r = 34'sd85004756;    4: r = 34'sd42667331;    5: r = 34'sd21354465;
      6: r = 34'sd10679838;    7: r = 34'sd5340245;     8: r = 34'sd2670163;
      9: r = 34'sd1335087;     10: r = 34'sd667544;     11: r = 34'sd333772;
      12: r = 34'sd166886;     13: r = 34'sd83443;      14: r = 34'sd41722;
      15: r = 34'sd20861;      16: r = 34'sd10430;      17: r = 34'sd5215;
      18: r = 34'sd2608;       19: r = 34'sd1304;       20: r = 34'sd652;
      21: r = 34'sd326;        22: r = 34'sd163;        23: r = 34'sd81;
      24: r = 34'sd41;         25: r = 34'sd20;         26: r = 34'sd10;
      27: r = 34'sd5;          28: r = 34'sd3;          29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/rva_cordic.sv
`default_nettype none
// One CORDIC micro-rotation per pipeline stage; payload rides alongside.
module rva_cordic #(
  parameter int PW = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [rva_pkg::CordicW-1:0]  in_z,
  input  wire logic [1:0]                          in_q,
  input  wire logic [PW-1:0]                       in_pay,
  output logic                                     out_valid,
  output logic signed [rva_pkg::CordicW-1:0]       out_x,
  output logic signed [rva_pkg::CordicW-1:0]       out_y,
  output logic [1:0]                               out_q,
  output logic [PW-1:0]                            out_pay
);
  localparam int N = rva_pkg::CordicSteps;
  localparam int W = rva_pkg::CordicW;

  logic signed [W-1:0] xs [N+1];
  logic signed [W-1:0] ys [N+1];
  logic signed [W-1:0] zs [N+1];
  logic [1:0]          qs [N+1];
  logic [PW-1:0]       ps [N+1];
  logic                vs [N+1];

  assign xs[0] = rva_pkg::CordicStart;
  assign ys[0] = '0;
  assign zs[0] = in_z;
  assign qs[0] = in_q;
  assign ps[0] = in_pay;
  assign vs[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        if (!zs[i][W-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - rva_pkg::atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + rva_pkg::atan_turn(i);
        end
        qs[i+1] <= qs[i];
        ps[i+1] <= ps[i];
      end
    end
  end

  assign out_valid = vs[N];
  assign out_x     = xs[N];
  assign out_y     = ys[N];
  assign out_q     = qs[N];
  assign out_pay   = ps[N];
endmodule
`default_nettype wire

### rtl/rva_matrix.sv
`default_nettype none
// Quadrant fold, Q.F rounding, Rodrigues matrix and row dot products.
module rva_matrix #(
  parameter int VW = 24,
  parameter int F  = 14
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [rva_pkg::CordicW-1:0] cx,
  input  wire logic signed [rva_pkg::CordicW-1:0] cy,
  input  wire logic [1:0]                         q,
  input  wire logic signed [3*VW-1:0]             vecs,
  input  wire logic signed [3*(F+2)-1:0]          axes,
  output logic                                    out_valid,
  output logic [3*VW-1:0]                         res
);
  localparam int W  = rva_pkg::CordicW;
  localparam int QW = F + 3;          // holds +-2^(F+1)
  localparam int MW = F + 4;          // matrix entry
  localparam int PW = VW + MW + 2;    // dot product
  localparam logic signed [QW-1:0] One = QW'(1) <<< F;
  localparam int NS = 6;

  function automatic logic signed [QW-1:0] clampq(input logic signed [W:0] a);
    logic signed [W:0] o;
    o = (W+1)'(1) <<< F;
    if (a > o) return One;
    if (a < -o) return -One;
    return QW'(a);
  endfunction

  function automatic logic signed [QW-1:0] rmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b) + ((2*QW)'(1) <<< (F-1));
    return QW'(p >>> F);
  endfunction

  logic [NS:1] v;
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[NS-1:1], in_valid};
  end

  // stage 1: fold quadrant, round, clamp axis
  logic signed [W:0] fc, fs, rc, rs;
  logic signed [QW-1:0] c1, s1, a1 [3];
  logic signed [VW-1:0] v1 [3], v2 [3], v3 [3], v4 [3];
  always_comb begin
    unique case (q)
      2'd0: begin fc = (W+1)'(cx);  fs = (W+1)'(cy);  end
      2'd1: begin fc = -(W+1)'(cy); fs = (W+1)'(cx);  end
      2'd2: begin fc = -(W+1)'(cx); fs = -(W+1)'(cy); end
      default: begin fc = (W+1)'(cy); fs = -(W+1)'(cx); end
    endcase
    rc = (fc + $signed((W+1)'(1) <<< (29 - F))) >>> (30 - F);
    rs = (fs + $signed((W+1)'(1) <<< (29 - F))) >>> (30 - F);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= clampq(rc);
      s1 <= clampq(rs);
      for (int k = 0; k < 3; k++) begin
        a1[k] <= clampq((W+1)'($signed(axes[k*(F+2) +: F+2])));
        v1[k] <= $signed(vecs[k*VW +: VW]);
      end
    end
  end

  // stage 2: aC, as
  logic signed [QW-1:0] c2, a2 [3], aC2 [3], as2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1;
      for (int k = 0; k < 3; k++) begin
        a2[k]  <= a1[k];
        aC2[k] <= rmul(a1[k], One - c1);
        as2[k] <= rmul(a1[k], s1);
        v2[k]  <= v1[k];
      end
    end
  end

  // stage 3: second products
  logic signed [QW-1:0] c3, as3 [3], sq3 [3], xyC, yzC, zxC;
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      for (int k = 0; k < 3; k++) begin
        as3[k] <= as2[k];
        sq3[k] <= rmul(a2[k], aC2[k]);
        v3[k]  <= v2[k];
      end
      xyC <= rmul(a2[0], aC2[1]);
      yzC <= rmul(a2[1], aC2[2]);
      zxC <= rmul(a2[2], aC2[0]);
    end
  end

  // stage 4: matrix entries
  logic signed [MW-1:0] m [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      m[0][0] <= MW'(sq3[0]) + MW'(c3);
      m[0][1] <= MW'(xyC) - MW'(as3[2]);
      m[0][2] <= MW'(zxC) + MW'(as3[1]);
      m[1][0] <= MW'(xyC) + MW'(as3[2]);
      m[1][1] <= MW'(sq3[1]) + MW'(c3);
      m[1][2] <= MW'(yzC) - MW'(as3[0]);
      m[2][0] <= MW'(zxC) - MW'(as3[1]);
      m[2][1] <= MW'(yzC) + MW'(as3[0]);
      m[2][2] <= MW'(sq3[2]) + MW'(c3);
      for (int k = 0; k < 3; k++) v4[k] <= v3[k];
    end
  end

  // stage 5: nine products
  logic signed [VW+MW-1:0] pr [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr[i][j] <= (VW+MW)'(v4[j]) * (VW+MW)'(m[i][j]);
    end
  end

  // stage 6: sum, round, saturate
  logic signed [PW-1:0] sm [3];
  logic [VW-1:0] sat [3];
  localparam logic signed [PW-1:0] VMax = (PW'(1) <<< (VW-1)) - 1;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[i] = (PW'(pr[i][0]) + PW'(pr[i][1]) + PW'(pr[i][2]) +
               $signed(PW'(1) <<< (F-1))) >>> F;
      if (sm[i] > VMax) sat[i] = VW'(VMax);
      else if (sm[i] < -VMax - 1) sat[i] = VW'(-VMax - 1);
      else sat[i] = VW'(sm[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) res[i*VW +: VW] <= sat[i];
    end
  end
  assign out_valid = v[NS];
endmodule
`default_nettype wire

### rtl/rotate_vector_about_axis.sv
`default_nettype none
// Channel | Dir | Contents
// s_axis  | in  | vec_x,vec_y,vec_z,axis_x,axis_y,axis_z,turn_angle
// m_axis  | out | out_x,out_y,out_z
// One transaction per clock while m_axis is not stalled; 30 CORDIC stages
// then 6 stages for fold, products, matrix, dot products and saturation.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// A stall on m_axis freezes the whole pipeline; nothing is dropped.
module rotate_vector_about_axis #(
  parameter int VEC_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14,
  parameter int ANGLE_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle (low bit up)
  input  wire logic [((3*VEC_WIDTH+3*(AXIS_FRAC_BITS+2)+ANGLE_BITS+7)/8)*8-1:0]
                    s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_x, out_y, out_z (low bit up)
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int PW = 3*VEC_WIDTH + 3*AW;
  localparam int W  = rva_pkg::CordicW;
  localparam int OB = ((3*VEC_WIDTH+7)/8)*8;

  // advance when output register free or being taken
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // scale angle to 32 bits, offset by an eighth turn
  logic [31:0] a32, t32;
  logic [ANGLE_BITS-1:0] ang;
  assign ang = s_axis_tdata[PW +: ANGLE_BITS];
  always_comb begin
    if (ANGLE_BITS >= 32) a32 = 32'(ang >> (ANGLE_BITS - 32));
    else a32 = 32'(ang) << (32 - ANGLE_BITS);
  end
  assign t32 = a32 + 32'h2000_0000;

  logic signed [W-1:0] z0;
  assign z0 = W'($signed({1'b0, t32[29:0]})) - W'(34'sh2000_0000);

  logic c_valid;
  logic signed [W-1:0] cx, cy;
  logic [1:0] cq;
  logic [PW-1:0] cpay;

  rva_cordic #(.PW(PW)) u_cordic (
    .clk, .rst, .en,
    .in_valid (s_axis_tvalid && en),
    .in_z     (z0),
    .in_q     (t32[31:30]),
    .in_pay   (s_axis_tdata[PW-1:0]),
    .out_valid(c_valid),
    .out_x    (cx),
    .out_y    (cy),
    .out_q    (cq),
    .out_pay  (cpay)
  );

  logic [3*VEC_WIDTH-1:0] res;
  logic mvalid;
  rva_matrix #(.VW(VEC_WIDTH), .F(AXIS_FRAC_BITS)) u_matrix (
    .clk, .rst, .en,
    .in_valid (c_valid),
    .cx, .cy,
    .q        (cq),
    .vecs     (cpay[3*VEC_WIDTH-1:0]),
    .axes     (cpay[PW-1:3*VEC_WIDTH]),
    .out_valid(mvalid),
    .res
  );

  assign m_axis_tvalid = mvalid;
  assign m_axis_tdata  = OB'(res);

  // stalled output must hold
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // input is taken whenever output side is free
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("ready low with empty output");
  // no output appears from nowhere right after reset
  assert property (@(posedge clk) $fell(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
endmodule
`default_nettype wire

### sim/rotate_vector_about_axis_tb.sv
`timescale 1ns / 100ps
module rotate_vector_about_axis_tb;

  localparam int VW = 24;
  localparam int FB = 14;
  localparam int AW = FB + 2;
  localparam int AB = 16;
  localparam int IN_W = ((3*VW + 3*AW + AB + 7)/8)*8;
  localparam int OUT_W = ((3*VW + 7)/8)*8;
  localparam int LATENCY = 36;
  localparam int N_RANDOM = 950;
  localparam longint ONE = 64'sd1 <<< FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // One rotation request and the rotated vector it produces
  typedef struct packed {
    logic [AB-1:0] turn_angle;
    logic signed [AW-1:0] axis_z, axis_y, axis_x;
    logic signed [VW-1:0] vec_z, vec_y, vec_x;
  } rot_req_t;

  typedef struct packed {
    logic signed [VW-1:0] out_z, out_y, out_x;
  } rot_vec_t;

  rot_req_t pending_reqs[$];
  rot_vec_t expected_vecs[$];
  int error_count = 0;
  bit stimulus_done = 1'b0;
  bit hold_sender = 1'b0;

  always #5 clk = ~clk;

  rotate_vector_about_axis DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic longint clampl(longint a, longint lo, longint hi);
    return a < lo ? lo : (a > hi ? hi : a);
  endfunction

  // Round-half-up right shift; >>> on a signed longint floors
  function automatic longint rnd_shift(longint a, int s);
    if (s == 0) return a;
    return (a + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, FB);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    return tbl[i];
  endfunction

  // Sine and cosine in Q.FB via a 30-step CORDIC on the folded angle
  function automatic void sine_cosine(input logic [AB-1:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a, t;
    longint x, y, z, dx, dy, cr, sr;
    a = {ang, {(32-AB){1'b0}}};
    t = a + 32'h2000_0000;
    x = 652032874;
    y = 0;
    z = longint'(t[29:0]) - 64'sd536870912;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    case (t[31:30])
      2'd0: begin cr = x; sr = y; end
      2'd1: begin cr = -y; sr = x; end
      2'd2: begin cr = -x; sr = -y; end
      default: begin cr = y; sr = -x; end
    endcase
    c = clampl(rnd_shift(cr, 30 - FB), -ONE, ONE);
    s = clampl(rnd_shift(sr, 30 - FB), -ONE, ONE);
  endfunction

  // Exact row dot product: |m| < 2^17, |v| <= 2^23, so the sum fits 64 bits
  function automatic logic signed [VW-1:0] dot_sat(longint m0, longint m1,
      longint m2, longint v0, longint v1, longint v2);
    longint acc;
    acc = rnd_shift(m0*v0 + m1*v1 + m2*v2, FB);
    return VW'(clampl(acc, -(64'sd1 <<< (VW-1)), (64'sd1 <<< (VW-1)) - 1));
  endfunction

  function automatic rot_vec_t rotate_vec(rot_req_t r);
    longint x, y, z, c, s, cc, xC, yC, zC, xs, ys, zs, xyC, yzC, zxC;
    longint v0, v1, v2;
    rot_vec_t o;
    v0 = r.vec_x; v1 = r.vec_y; v2 = r.vec_z;
    x = clampl(r.axis_x, -ONE, ONE);
    y = clampl(r.axis_y, -ONE, ONE);
    z = clampl(r.axis_z, -ONE, ONE);
    sine_cosine(r.turn_angle, c, s);
    cc = ONE - c;
    xC = qmul(x, cc); yC = qmul(y, cc); zC = qmul(z, cc);
    xs = qmul(x, s); ys = qmul(y, s); zs = qmul(z, s);
    xyC = qmul(x, yC); yzC = qmul(y, zC); zxC = qmul(z, xC);
    o.out_x = dot_sat(qmul(x, xC) + c, xyC - zs, zxC + ys, v0, v1, v2);
    o.out_y = dot_sat(xyC + zs, qmul(y, yC) + c, yzC - xs, v0, v1, v2);
    o.out_z = dot_sat(zxC - ys, yzC + xs, qmul(z, zC) + c, v0, v1, v2);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [VW-1:0] rand_vec_comp();
    case ($urandom_range(0, 5))
      0: return VW'(-(1 <<< (VW-1)));
      1: return VW'((1 <<< (VW-1)) - 1);
      2: return VW'($signed($urandom_range(0, 2000)) - 1000);
      default: return VW'($urandom);
    endcase
  endfunction

  // Mostly near-unit axes; some raw 16-bit noise reaches the clamp
  function automatic logic signed [AW-1:0] rand_axis_comp();
    case ($urandom_range(0, 7))
      0: return AW'($urandom);
      1: return AW'(ONE);
      2: return AW'(-ONE);
      3: return '0;
      default: return AW'($signed($urandom_range(0, 2*ONE)) - ONE);
    endcase
  endfunction

  function automatic rot_req_t make_req(longint vx, longint vy, longint vz,
      longint ax, longint ay, longint az, longint ang);
    rot_req_t r;
    r.vec_x = VW'(vx); r.vec_y = VW'(vy); r.vec_z = VW'(vz);
    r.axis_x = AW'(ax); r.axis_y = AW'(ay); r.axis_z = AW'(az);
    r.turn_angle = AB'(ang);
    return r;
  endfunction

  // Fill the queue of pending transactions
  initial begin
    longint vmax, vmin;
    rot_req_t r;
    vmax = (64'sd1 <<< (VW-1)) - 1;
    vmin = -(64'sd1 <<< (VW-1));
    // Directed: quadrant boundaries, identity, extremes, zero axis, oversize
    pending_reqs.push_back(make_req(1000, 2000, 3000, 0, 0, ONE, 0));
    pending_reqs.push_back(make_req(1000, 2000, 3000, 0, 0, ONE, 16384));
    pending_reqs.push_back(make_req(1000, 2000, 3000, 0, 0, ONE, 32768));
    pending_reqs.push_back(make_req(1000, 2000, 3000, 0, 0, ONE, 49152));
    pending_reqs.push_back(make_req(1000, 2000, 3000, 0, 0, ONE, 65535));
    pending_reqs.push_back(make_req(vmax, vmax, vmax, ONE, 0, 0, 8192));
    pending_reqs.push_back(make_req(vmin, vmin, vmin, 0, ONE, 0, 8192));
    pending_reqs.push_back(make_req(vmax, vmin, vmax, 0, 0, -ONE, 24576));
    pending_reqs.push_back(make_req(vmax, vmax, vmax, 9459, 9459, 9459, 40960));
    pending_reqs.push_back(make_req(vmin, vmin, vmin, -9459, -9459, -9459, 12345));
    pending_reqs.push_back(make_req(5, -7, 9, 0, 0, 0, 10000));
    pending_reqs.push_back(make_req(vmax, vmin, 0, 0, 0, 0, 32768));
    pending_reqs.push_back(make_req(123456, -654321, 777, 32767, -32768, 20000, 30000));
    pending_reqs.push_back(make_req(vmax, vmax, vmin, 32767, 32767, 32767, 1000));
    pending_reqs.push_back(make_req(-1, -1, -1, -32768, -32768, -32768, 50000));
    pending_reqs.push_back(make_req(0, 0, 0, ONE, 0, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      r.vec_x = rand_vec_comp(); r.vec_y = rand_vec_comp();
      r.vec_z = rand_vec_comp();
      r.axis_x = rand_axis_comp(); r.axis_y = rand_axis_comp();
      r.axis_z = rand_axis_comp();
      r.turn_angle = AB'($urandom);
      pending_reqs.push_back(r);
    end
    stimulus_done = 1'b1;
  end

  // Driver: draw a gap per transaction, hold tdata until accepted
  int send_gap = 0;
  int sent_count = 0;
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= $urandom_range(0, 15);
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      gap = send_gap;
      if (s_axis_tvalid) begin
        expected_vecs.push_back(rotate_vec(rot_req_t'(s_axis_tdata[3*VW+3*AW+AB-1:0])));
        sent_count <= sent_count + 1;
        // Long stretches without gaps in the last third of every 300
        gap = (sent_count % 300 > 200) ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= gap - 1;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(pending_reqs.pop_front());
        send_gap <= 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        send_gap <= 0;
      end
    end
  end

  // Drain the pipeline completely once, halfway through
  initial begin
    wait (sent_count >= 400);
    hold_sender = 1'b1;
    wait (expected_vecs.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    hold_sender = 1'b0;
  end

  // Monitor: random back-pressure, compare against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    rot_vec_t got, want;
    int st;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = rot_vec_t'(m_axis_tdata[3*VW-1:0]);
        if (expected_vecs.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = expected_vecs.pop_front();
          if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
          if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
          if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
        end
        st = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
        stall_left <= (st > 0) ? st - 1 : 0;
        m_axis_tready <= (st == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Reset, then wait for the stream to drain
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done && pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_vecs.size() == 0);
    repeat (2*LATENCY) @(posedge clk);
    if (error_count == 0 && expected_vecs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### rotate_vector_about_axis.f
rtl/rva_pkg.sv
rtl/rva_cordic.sv
rtl/rva_matrix.sv
rtl/rotate_vector_about_axis.sv
sim/rotate_vector_about_axis_tb.sv
